>>> rtl/msic_pkg.sv
// Shared types and constants for the merge sort inversion counter.
package msic_pkg;

  localparam int ValueW = 32;
  localparam int IndexW = 10;
  localparam int CountW = 19;
  localparam int StatusW = 2;

  localparam logic [CountW-1:0] CountMax = 19'h7FFFF;

  localparam logic ModeLoad = 1'b0;
  localparam logic ModeRead = 1'b1;

  localparam logic [StatusW-1:0] StatusOk       = 2'd0;
  localparam logic [StatusW-1:0] StatusOverflow = 2'd1;
  localparam logic [StatusW-1:0] StatusRange    = 2'd2;

  typedef struct packed {
    logic                     mode;
    logic signed [ValueW-1:0] value;
    logic [IndexW-1:0]        index;
    logic                     last;
  } msic_in_t;

  typedef struct packed {
    logic signed [ValueW-1:0] sorted_value;
    logic [CountW-1:0]        inversion_count;
    logic                     inversion_parity;
    logic [StatusW-1:0]       status;
  } msic_out_t;

  // Status of the merge engine toward the control logic.
  typedef struct packed {
    logic busy;
    logic done;
    logic pass_end;
    logic add_en;
  } msic_eng_t;

endpackage

>>> rtl/msic_ram.sv
// Generic synchronous RAM with one write port and two registered read ports.
module msic_ram #(
  parameter int Width = 32,
  parameter int Depth = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr0_i,
  input  logic [$clog2(Depth)-1:0] raddr1_i,
  output logic [Width-1:0]         rdata0_o,
  output logic [Width-1:0]         rdata1_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata0_o <= mem_q[raddr0_i];
    rdata1_o <= mem_q[raddr1_i];
  end

endmodule

>>> rtl/msic_merge.sv
// Bottom-up merge: walks passes and runs, one word per cycle except in setup.
module msic_merge import msic_pkg::*; #(
  parameter int MAX_ITEMS = 1024
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 start_i,
  input  logic [$clog2(MAX_ITEMS+1)-1:0]       count_i,
  input  logic signed [ValueW-1:0]             src0_i,
  input  logic signed [ValueW-1:0]             src1_i,
  output logic [$clog2(MAX_ITEMS)-1:0]         raddr0_o,
  output logic [$clog2(MAX_ITEMS)-1:0]         raddr1_o,
  output logic                                 we_o,
  output logic [$clog2(MAX_ITEMS)-1:0]         waddr_o,
  output logic signed [ValueW-1:0]             wdata_o,
  output logic [$clog2(MAX_ITEMS+1)-1:0]       add_o,
  output msic_eng_t                            stat_o
);

  localparam int AW = $clog2(MAX_ITEMS);
  localparam int CW = $clog2(MAX_ITEMS + 1);
  localparam int PW = CW + 2;

  typedef enum logic [1:0] {StIdle, StSetup, StMerge} state_e;

  state_e        state_q, state_d;
  logic [PW-1:0] n_q, n_d, w_q, w_d, lo_q, lo_d;
  logic [PW-1:0] mid_q, mid_d, hi_q, hi_d;
  logic [PW-1:0] p_q, p_d, q_q, q_d, k_q, k_d;
  logic [PW-1:0] lo_w, lo_2w, w_2;
  logic          take_left;

  always_comb begin
    state_d = state_q;
    n_d     = n_q;
    w_d     = w_q;
    lo_d    = lo_q;
    mid_d   = mid_q;
    hi_d    = hi_q;
    p_d     = p_q;
    q_d     = q_q;
    k_d     = k_q;
    we_o    = 1'b0;
    add_o   = '0;
    stat_o  = '0;
    stat_o.busy = (state_q != StIdle);
    w_2     = w_q << 1;
    lo_w    = lo_q + w_q;
    lo_2w   = lo_q + w_2;
    take_left = (p_q <= mid_q) && ((q_q > hi_q) || (src0_i <= src1_i));
    waddr_o = k_q[AW-1:0];
    wdata_o = take_left ? src0_i : src1_i;

    unique case (state_q)
      StIdle: begin
        if (start_i) begin
          n_d     = PW'(count_i);
          w_d     = PW'(1);
          lo_d    = '0;
          state_d = StSetup;
        end
      end
      StSetup: begin
        // A run whose right half lies past the end is copied as it is.
        mid_d   = (lo_w > n_q) ? n_q - PW'(1) : lo_w - PW'(1);
        hi_d    = (lo_2w > n_q) ? n_q - PW'(1) : lo_2w - PW'(1);
        p_d     = lo_q;
        q_d     = lo_w;
        k_d     = lo_q;
        state_d = StMerge;
      end
      StMerge: begin
        we_o = 1'b1;
        k_d  = k_q + PW'(1);
        if (take_left) begin
          p_d = p_q + PW'(1);
        end else begin
          q_d = q_q + PW'(1);
          if (p_q <= mid_q) begin
            stat_o.add_en = 1'b1;
            add_o = CW'(mid_q - p_q + PW'(1));
          end
        end
        if (k_q == hi_q) begin
          if (lo_2w < n_q) begin
            lo_d    = lo_2w;
            state_d = StSetup;
          end else begin
            stat_o.pass_end = 1'b1;
            w_d = w_2;
            if (w_2 < n_q) begin
              lo_d    = '0;
              state_d = StSetup;
            end else begin
              stat_o.done = 1'b1;
              state_d     = StIdle;
            end
          end
        end
      end
      default: state_d = StIdle;
    endcase

    // Address the next heads so that their words arrive in the next cycle.
    raddr0_o = p_d[AW-1:0];
    raddr1_o = q_d[AW-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    n_q   <= n_d;
    w_q   <= w_d;
    lo_q  <= lo_d;
    mid_q <= mid_d;
    hi_q  <= hi_d;
    p_q   <= p_d;
    q_q   <= q_d;
    k_q   <= k_d;
  end

endmodule

>>> rtl/merge_sort_inversion_counter_core.sv
// Top level of the merge sort inversion counter.
//
// Usage: a word is accepted on data_i at a rising edge where start is high
// and busy is low. A load word (mode 0) writes one element and returns
// nothing; loads past MAX_ITEMS are dropped and the set is flagged.
// A load word with last set closes the set: the block sorts it ascending and
// stable and counts inversions, then shows one result word (sorted_value 0,
// count saturated at 19 bits, exact parity, status overflow or ok).
// A read word (mode 1) returns the element at index of the current set, or
// status range when the index is not below the loaded count.
// Results appear on result_o, marked by strobe_o for exactly one cycle; the
// receiver cannot stall, and busy may drop in that same cycle.
// A read is answered through the read state and the result register. A sort
// of n elements runs ceil(log2 n) passes; each pass streams all n elements,
// with a setup step per run pair, and the result word follows through the
// finish state. The merge is bound by one element per cycle outside setup
// steps, through the write port of the destination memory. Two memories
// alternate as source and destination per pass, so no copy back is needed.
// Reset clears the count, flags and control; the memories are not cleared.
module merge_sort_inversion_counter_core import msic_pkg::*; #(
  parameter int MAX_ITEMS = 1024
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      start,
  output logic      busy,
  input  msic_in_t  data_i,
  output logic      strobe_o,
  output msic_out_t result_o
);

  localparam int AW   = $clog2(MAX_ITEMS);
  localparam int CW   = $clog2(MAX_ITEMS + 1);
  localparam int TW   = (2 * CW > 20) ? 2 * CW : 20;
  localparam int CmpW = (CW > IndexW) ? CW : IndexW;

  typedef enum logic [1:0] {StIdle, StSort, StFinish, StRead} state_e;

  state_e          state_q, state_d;
  logic [CW-1:0]   count_q, count_d;
  logic [TW-1:0]   total_q, total_d;
  logic            ovf_q, ovf_d;
  logic            closed_q, closed_d;
  logic            cur_q, cur_d;
  logic            rd_ok_q, rd_ok_d;
  logic            strobe_q, strobe_d;
  msic_out_t       result_q, result_d;

  logic            accept, do_load, do_read, load_we, has_room, idx_ok, eng_start;
  logic [CW-1:0]   eff_cnt, new_cnt;
  logic [AW-1:0]   rd_addr, raddr0, raddr1, waddr;
  logic [ValueW-1:0] wdata;
  logic            we_a, we_b;
  logic [ValueW-1:0] a_rd0, a_rd1, b_rd0, b_rd1;
  logic signed [ValueW-1:0] src0, src1;
  logic [CountW-1:0] count_sat;

  logic [AW-1:0]   eng_raddr0, eng_raddr1, eng_waddr;
  logic            eng_we;
  logic signed [ValueW-1:0] eng_wdata;
  logic [CW-1:0]   eng_add;
  msic_eng_t       eng_stat;

  assign busy     = (state_q != StIdle);
  assign strobe_o = strobe_q;
  assign result_o = result_q;

  assign accept  = start && !busy;
  assign do_load = accept && (data_i.mode == ModeLoad);
  assign do_read = accept && (data_i.mode == ModeRead);

  // A load after a closed set starts a fresh one at position zero.
  assign eff_cnt  = closed_q ? '0 : count_q;
  assign has_room = eff_cnt < CW'(MAX_ITEMS);
  assign new_cnt  = has_room ? eff_cnt + CW'(1) : eff_cnt;
  assign load_we  = do_load && has_room;

  assign idx_ok  = CmpW'(data_i.index) < CmpW'(count_q);
  assign rd_addr = AW'(data_i.index);

  // The memory selected by cur_q holds the current set; the other one is the
  // merge destination during a pass.
  assign waddr  = load_we ? eff_cnt[AW-1:0] : eng_waddr;
  assign wdata  = load_we ? data_i.value : eng_wdata;
  assign we_a   = (load_we && !cur_q) || (eng_we && cur_q);
  assign we_b   = (load_we && cur_q) || (eng_we && !cur_q);
  assign raddr0 = (state_q == StSort) ? eng_raddr0 : rd_addr;
  assign raddr1 = eng_raddr1;
  assign src0   = cur_q ? b_rd0 : a_rd0;
  assign src1   = cur_q ? b_rd1 : a_rd1;

  assign count_sat = (total_q > TW'(CountMax)) ? CountMax : total_q[CountW-1:0];

  msic_ram #(.Width(ValueW), .Depth(MAX_ITEMS)) u_ram_a (
    .clk_i    (clk_i),
    .we_i     (we_a),
    .waddr_i  (waddr),
    .wdata_i  (wdata),
    .raddr0_i (raddr0),
    .raddr1_i (raddr1),
    .rdata0_o (a_rd0),
    .rdata1_o (a_rd1)
  );

  msic_ram #(.Width(ValueW), .Depth(MAX_ITEMS)) u_ram_b (
    .clk_i    (clk_i),
    .we_i     (we_b),
    .waddr_i  (waddr),
    .wdata_i  (wdata),
    .raddr0_i (raddr0),
    .raddr1_i (raddr1),
    .rdata0_o (b_rd0),
    .rdata1_o (b_rd1)
  );

  msic_merge #(.MAX_ITEMS(MAX_ITEMS)) u_merge (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (eng_start),
    .count_i  (new_cnt),
    .src0_i   (src0),
    .src1_i   (src1),
    .raddr0_o (eng_raddr0),
    .raddr1_o (eng_raddr1),
    .we_o     (eng_we),
    .waddr_o  (eng_waddr),
    .wdata_o  (eng_wdata),
    .add_o    (eng_add),
    .stat_o   (eng_stat)
  );

  always_comb begin
    state_d   = state_q;
    count_d   = count_q;
    total_d   = total_q;
    ovf_d     = ovf_q;
    closed_d  = closed_q;
    cur_d     = cur_q;
    rd_ok_d   = rd_ok_q;
    strobe_d  = 1'b0;
    result_d  = result_q;
    eng_start = 1'b0;

    // A new set or a closing load restarts the inversion total.
    if (do_load && (closed_q || data_i.last)) begin
      total_d = '0;
    end else if (eng_stat.add_en) begin
      total_d = total_q + TW'(eng_add);
    end

    if (eng_stat.pass_end) begin
      cur_d = !cur_q;
    end

    unique case (state_q)
      StIdle: begin
        if (do_load) begin
          count_d  = new_cnt;
          ovf_d    = (closed_q ? 1'b0 : ovf_q) || !has_room;
          closed_d = data_i.last;
          if (data_i.last) begin
            if (new_cnt >= CW'(2)) begin
              eng_start = 1'b1;
              state_d   = StSort;
            end else begin
              state_d = StFinish;
            end
          end
        end else if (do_read) begin
          rd_ok_d = idx_ok;
          state_d = StRead;
        end
      end
      StSort: begin
        if (eng_stat.done) begin
          state_d = StFinish;
        end
      end
      StFinish: begin
        strobe_d                  = 1'b1;
        result_d.sorted_value     = '0;
        result_d.inversion_count  = count_sat;
        result_d.inversion_parity = total_q[0];
        result_d.status           = ovf_q ? StatusOverflow : StatusOk;
        state_d                   = StIdle;
      end
      StRead: begin
        strobe_d                  = 1'b1;
        result_d.sorted_value     = rd_ok_q ? src0 : '0;
        result_d.inversion_count  = count_sat;
        result_d.inversion_parity = total_q[0];
        result_d.status           = rd_ok_q ? StatusOk : StatusRange;
        state_d                   = StIdle;
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= StIdle;
      count_q  <= '0;
      total_q  <= '0;
      ovf_q    <= 1'b0;
      closed_q <= 1'b0;
      cur_q    <= 1'b0;
      rd_ok_q  <= 1'b0;
      strobe_q <= 1'b0;
      result_q <= '0;
    end else begin
      state_q  <= state_d;
      count_q  <= count_d;
      total_q  <= total_d;
      ovf_q    <= ovf_d;
      closed_q <= closed_d;
      cur_q    <= cur_d;
      rd_ok_q  <= rd_ok_d;
      strobe_q <= strobe_d;
      result_q <= result_d;
    end
  end

  // No result strobe directly follows another.
  a_strobe_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    strobe_o |=> !strobe_o)
    else $error("result strobe on two consecutive cycles");

  // A read word is answered through the read state and the result register.
  a_read_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && data_i.mode == ModeRead) |=> ##1 strobe_o)
    else $error("read result missing");

  // A load word without last produces no result.
  a_load_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && data_i.mode == ModeLoad && !data_i.last) |=> ##1 !strobe_o)
    else $error("result after a plain load");

  // The control sequencer and the merge engine agree on when a sort runs.
  a_sort_sync: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StSort) == eng_stat.busy)
    else $error("sort state and merge engine out of step");

endmodule

>>> tb/msic_result_checker.sv
// Checker for the merge sort inversion counter: shadow model, expected words and comparison.
`timescale 1ns / 1ps

module msic_result_checker import msic_pkg::*; #(
  parameter int MAX_ITEMS = 1024
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      start_i,
  input  logic      busy_i,
  input  msic_in_t  data_i,
  input  logic      strobe_i,
  input  msic_out_t result_i,
  output int        errors_o,
  output int        pending_o,
  output int        checked_o
);

  // Shadow copy of the block's set and the results of its latest sort.
  logic signed [ValueW-1:0] shadow_mem [MAX_ITEMS];
  int unsigned              shadow_count      = 0;
  longint                   shadow_inversions = 0;
  bit                       shadow_overflow   = 1'b0;
  bit                       set_closed        = 1'b0;

  int error_count   = 0;
  int pending_count = 0;
  int checked_count = 0;

  msic_out_t awaited_results [$];

  assign errors_o  = error_count;
  assign pending_o = pending_count;
  assign checked_o = checked_count;

  // A stable insertion sort moves each element past exactly the larger
  // elements ahead of it, so the shift count is the inversion count.
  task automatic sort_and_count_inversions();
    logic signed [ValueW-1:0] key;
    int                       j;
    shadow_inversions = 0;
    for (int i = 1; i < int'(shadow_count); i++) begin
      key = shadow_mem[i];
      j = i;
      while (j > 0 && shadow_mem[j-1] > key) begin
        shadow_mem[j] = shadow_mem[j-1];
        j--;
        shadow_inversions++;
      end
      shadow_mem[j] = key;
    end
  endtask

  task automatic shadow_accept(input msic_in_t w);
    msic_out_t r;
    r = '0;
    if (w.mode == ModeLoad) begin
      // A load after a closed set starts a fresh one.
      if (set_closed) begin
        shadow_count      = 0;
        shadow_inversions = 0;
        shadow_overflow   = 1'b0;
        set_closed        = 1'b0;
      end
      if (shadow_count < MAX_ITEMS) begin
        shadow_mem[shadow_count] = w.value;
        shadow_count++;
      end else begin
        shadow_overflow = 1'b1;
      end
      if (!w.last) begin
        return;
      end
      sort_and_count_inversions();
      set_closed = 1'b1;
      r.status = shadow_overflow ? StatusOverflow : StatusOk;
    end else if (w.index < shadow_count) begin
      r.sorted_value = shadow_mem[w.index];
      r.status       = StatusOk;
    end else begin
      r.status = StatusRange;
    end
    r.inversion_count  = (shadow_inversions > CountMax) ? CountMax
                                                        : shadow_inversions[CountW-1:0];
    r.inversion_parity = shadow_inversions[0];
    awaited_results.insert(awaited_results.size(), r);
  endtask

  // Everything is sampled on the falling edge, where inputs and outputs are
  // stable; a word seen here with start high and busy low is taken at the
  // next rising edge.
  always @(negedge clk_i) begin
    msic_out_t want;
    if (rst_ni) begin
      if (strobe_i) begin
        if (awaited_results.size() == 0) begin
          $error("result word with no expectation waiting");
          error_count++;
        end else begin
          want = awaited_results.pop_front();
          checked_count++;
          if (result_i.sorted_value !== want.sorted_value) begin
            $error("sorted_value: expected %0d, got %0d",
                   want.sorted_value, result_i.sorted_value);
            error_count++;
          end
          if (result_i.inversion_count !== want.inversion_count) begin
            $error("inversion_count: expected %0d, got %0d",
                   want.inversion_count, result_i.inversion_count);
            error_count++;
          end
          if (result_i.inversion_parity !== want.inversion_parity) begin
            $error("inversion_parity: expected %0d, got %0d",
                   want.inversion_parity, result_i.inversion_parity);
            error_count++;
          end
          if (result_i.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, result_i.status);
            error_count++;
          end
        end
      end
      if (start_i && !busy_i) begin
        shadow_accept(data_i);
      end
      pending_count = awaited_results.size();
    end
  end

endmodule

>>> tb/merge_sort_inversion_counter_core_tb.sv
// Top of the merge sort inversion counter testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module merge_sort_inversion_counter_core_tb;
  import msic_pkg::*;

  localparam int MaxItems    = 1024;
  localparam int HalfPeriod  = 10;
  // The limit leaves a wide margin over a full 1024 element sort, during which
  // no word is taken or returned.
  localparam int StallLimit  = 80000;
  localparam int RandomWords = 850;
  localparam int SettleWait  = 20;

  logic      clk_i;
  logic      rst_ni;
  logic      start;
  logic      busy;
  msic_in_t  data_w;
  logic      strobe;
  msic_out_t result_w;

  int errors;
  int pending;
  int checked;

  // Driver bookkeeping: a rough mirror of the set size, only used to aim
  // read indexes, plus numbers for the closing summary.
  int unsigned mirror_count;
  bit          mirror_closed;
  int          words_sent;
  int          sets_closed;
  int          largest_set;
  int          idle_pct;
  int          stall_cycles = 0;

  merge_sort_inversion_counter_core #(
    .MAX_ITEMS(MaxItems)
  ) uut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start   (start),
    .busy    (busy),
    .data_i  (data_w),
    .strobe_o(strobe),
    .result_o(result_w)
  );

  msic_result_checker #(
    .MAX_ITEMS(MaxItems)
  ) u_checker (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start),
    .busy_i   (busy),
    .data_i   (data_w),
    .strobe_i (strobe),
    .result_i (result_w),
    .errors_o (errors),
    .pending_o(pending),
    .checked_o(checked)
  );

  initial begin
    clk_i = 1'b0;
  end

  always #HalfPeriod clk_i = ~clk_i;

  // Watchdog: counts cycles in which no word is taken and no result shows.
  // Sampled on the falling edge so it never races the block's flops.
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if ((start && !busy) || strobe) begin
        stall_cycles = 0;
      end else begin
        stall_cycles++;
      end
      if (stall_cycles >= StallLimit) begin
        $display("merge_sort_inversion_counter_core_tb: done, errors");
        $finish;
      end
    end
  end

  // The sender's idle rate steps through phases as the run goes on: none,
  // half the cycles, none again, then a light fourteen percent.
  function automatic int idle_for_phase(input int sent);
    case ((sent / 120) % 4)
      1:       idle_for_phase = 50;
      3:       idle_for_phase = 14;
      default: idle_for_phase = 0;
    endcase
  endfunction

  // Load words carry a random index and read words a random value, so the
  // unused fields toggle too.
  function automatic msic_in_t make_load(input logic signed [ValueW-1:0] v, input bit fin);
    msic_in_t w;
    w.mode  = ModeLoad;
    w.value = v;
    w.index = IndexW'($urandom);
    w.last  = fin;
    return w;
  endfunction

  function automatic msic_in_t make_read(input logic [IndexW-1:0] idx, input bit fin);
    msic_in_t w;
    w.mode  = ModeRead;
    w.value = ValueW'($urandom);
    w.index = idx;
    w.last  = fin;
    return w;
  endfunction

  // Mostly an index inside the current set, sometimes anywhere in the
  // 10 bit range, which usually lands out of range.
  function automatic logic [IndexW-1:0] pick_index();
    int unsigned span;
    span = (mirror_count > MaxItems) ? MaxItems : mirror_count;
    if (span > 0 && $urandom_range(0, 99) < 80) begin
      return IndexW'($urandom_range(0, span - 1));
    end
    return IndexW'($urandom_range(0, 1023));
  endfunction

  // Offers one word. The handshake is judged on the falling edge, where
  // busy is settled; the word is then taken at the following rising edge,
  // and the next drive happens at that same edge with a single assignment.
  task automatic send_word(input msic_in_t w);
    idle_pct = idle_for_phase(words_sent);
    while ($urandom_range(0, 99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk_i);
    end
    start  <= 1'b1;
    data_w <= w;
    do begin
      @(negedge clk_i);
    end while (busy);
    @(posedge clk_i);
    words_sent++;
    if (w.mode == ModeLoad) begin
      if (mirror_closed) begin
        mirror_count  = 0;
        mirror_closed = 1'b0;
      end
      mirror_count++;
      if (w.last) begin
        mirror_closed = 1'b1;
        sets_closed++;
        if (int'(mirror_count) > largest_set) begin
          largest_set = mirror_count;
        end
      end
    end
  endtask

  // The sender holds off until every expected result word has come back.
  task automatic drain_results();
    start <= 1'b0;
    do begin
      @(posedge clk_i);
    end while (pending != 0);
  endtask

  initial begin
    int                       stop_at;
    int                       roll;
    int                       set_len;
    int                       style;
    logic signed [ValueW-1:0] base;
    logic signed [ValueW-1:0] step;
    logic signed [ValueW-1:0] v;

    rst_ni        = 1'b0;
    start         = 1'b0;
    data_w        = '0;
    mirror_count  = 0;
    mirror_closed = 1'b0;
    words_sent    = 0;
    sets_closed   = 0;
    largest_set   = 0;
    idle_pct      = 0;

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part. Reads before any set exist are out of range, with a
    // count of zero; a read with last set must not start anything.
    send_word(make_read(10'd0, 1'b0));
    send_word(make_read(10'd1023, 1'b1));
    // A one element set has no inversions; extreme negative value.
    send_word(make_load(32'sh8000_0000, 1'b1));
    send_word(make_read(10'd0, 1'b0));
    send_word(make_read(10'd1, 1'b0));
    // A new set after a closed one; reads before the sort see load order.
    send_word(make_load(32'sh7FFF_FFFF, 1'b0));
    send_word(make_load(32'sh8000_0000, 1'b0));
    send_word(make_read(10'd0, 1'b0));
    send_word(make_load(32'sh0000_0000, 1'b0));
    send_word(make_load(32'shFFFF_FFFF, 1'b0));
    send_word(make_read(10'd2, 1'b1));
    send_word(make_load(32'sh0000_0005, 1'b1));
    send_word(make_read(10'd0, 1'b0));
    send_word(make_read(10'd4, 1'b0));
    send_word(make_read(10'd5, 1'b0));
    // Equal values: no inversions, and the order must stay stable.
    send_word(make_load(32'sd3, 1'b0));
    send_word(make_load(32'sd3, 1'b0));
    send_word(make_load(32'sd3, 1'b1));
    send_word(make_read(10'd2, 1'b0));
    // A strictly descending set of four gives six inversions, even parity.
    send_word(make_load(32'sd4, 1'b0));
    send_word(make_load(32'sd2, 1'b0));
    send_word(make_load(32'sd0, 1'b0));
    send_word(make_load(-32'sd2, 1'b1));
    drain_results();

    // Capacity: a full store plus a few dropped loads, the last of which
    // closes the set; the sort still runs and reports the overflow.
    for (int i = 0; i < MaxItems + 6; i++) begin
      send_word(make_load(ValueW'($urandom), i == MaxItems + 5));
    end
    send_word(make_read(10'd0, 1'b0));
    send_word(make_read(10'd1023, 1'b0));
    send_word(make_read(pick_index(), 1'b0));
    drain_results();

    // Random part: mostly whole sets with random contents followed by
    // reads, the rest loose words that break sets up at random points.
    stop_at = words_sent + RandomWords;
    while (words_sent < stop_at) begin
      roll = $urandom_range(0, 99);
      if (roll < 4) begin
        drain_results();
      end
      if (roll < 85) begin
        set_len = ($urandom_range(0, 9) == 0) ? $urandom_range(25, 200)
                                               : $urandom_range(1, 24);
        style   = $urandom_range(0, 3);
        base    = ValueW'($urandom);
        step    = ValueW'($urandom_range(0, 1000));
        for (int i = 0; i < set_len; i++) begin
          case (style)
            0:       v = ValueW'($urandom);
            1:       v = ValueW'($urandom_range(0, 8)) - 32'sd4;
            2:       v = base + step * i;
            default: v = base - step * i;
          endcase
          send_word(make_load(v, i == set_len - 1));
          // Now and then a read lands in the middle of loading.
          if ($urandom_range(0, 19) == 0) begin
            send_word(make_read(pick_index(), 1'($urandom_range(0, 1))));
          end
        end
        repeat ($urandom_range(1, 6)) begin
          send_word(make_read(pick_index(), 1'($urandom_range(0, 1))));
        end
      end else begin
        repeat ($urandom_range(1, 8)) begin
          if ($urandom_range(0, 1) == 0) begin
            send_word(make_read(pick_index(), 1'($urandom_range(0, 1))));
          end else begin
            send_word(make_load(ValueW'($urandom), $urandom_range(0, 7) == 0));
          end
        end
      end
    end

    // Wind down: wait for every expected word, then a short settle time.
    drain_results();
    repeat (SettleWait) @(posedge clk_i);

    $display("Run covered %0d words in %0d closed sets (largest %0d loads, overflow included).",
             words_sent, sets_closed, largest_set);
    $display("%0d result words were compared field by field.", checked);
    if (errors == 0 && pending == 0) begin
      $display("merge_sort_inversion_counter_core_tb: done, clean");
    end else begin
      $display("merge_sort_inversion_counter_core_tb: done, errors");
    end
    $finish;
  end

endmodule
